// ===== src/per_tag_distance_averager_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PER_TAG_DISTANCE_AVERAGER_MACROS_SVH
`define PER_TAG_DISTANCE_AVERAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PTDA_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ptda check failed");

// Next-cycle implication, disabled while reset is low.
`define PTDA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ptda check failed");

`endif

// ===== src/ptda_pkg.sv =====
`timescale 1ns / 1ps

package ptda_pkg;

    localparam int ANCHORS         = 4;
    localparam int ANC_W           = 2;
    localparam int DIST_W          = 16;
    localparam int TAG_W           = 4;
    localparam int OP_W            = 2;
    localparam int MINA_W          = 3;
    localparam logic [MINA_W-1:0] MINA_RESET = 3'd3;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TAG_COUNT_DEF   = 16;
    localparam int COUNT_LIMIT_DEF = 255;
    localparam int SUM_W_DEF       = 24;
    localparam int CNT_W_DEF       = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INJECT   = 2'd0,
        OP_READ     = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_READ_ALL = 2'd3
    } t_op;

endpackage

// ===== src/ptda_if.sv =====
`timescale 1ns / 1ps

interface ptda_in_if import ptda_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [TAG_W-1:0]  tag;
    logic [DIST_W-1:0] dist0;
    logic [DIST_W-1:0] dist1;
    logic [DIST_W-1:0] dist2;
    logic [DIST_W-1:0] dist3;

    modport source (output valid, opcode, tag, dist0, dist1, dist2, dist3, input ready);
    modport sink (input valid, opcode, tag, dist0, dist1, dist2, dist3, output ready);
endinterface

interface ptda_out_if import ptda_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  tag_out;
    logic              valid_res;
    logic [DIST_W-1:0] mean0;
    logic [DIST_W-1:0] mean1;
    logic [DIST_W-1:0] mean2;
    logic [DIST_W-1:0] mean3;
    logic              last;

    modport source (output valid, tag_out, valid_res, mean0, mean1, mean2, mean3, last,
                    input ready);
    modport sink (input valid, tag_out, valid_res, mean0, mean1, mean2, mean3, last,
                  output ready);
endinterface

interface ptda_cfg_if import ptda_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MINA_W-1:0] min_anchors;

    modport source (output valid, min_anchors, input ready);
    modport sink (input valid, min_anchors, output ready);
endinterface

// ===== src/ptda_div.sv =====
`timescale 1ns / 1ps

module ptda_div import ptda_pkg::*; #(
    parameter int SUM_W = SUM_W_DEF,
    parameter int CNT_W = CNT_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [CNT_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DIST_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    partial;
    logic              ge;

    // Restoring division: one quotient bit per cycle, shifted into the dividend register.
    assign partial = {r_rem, r_dvd[SUM_W-1]};
    assign ge      = partial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? CNT_W'(partial - {1'b0, r_dsr}) : CNT_W'(partial);
            r_dvd <= {r_dvd[SUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd[DIST_W-1:0];

endmodule

// ===== src/per_tag_distance_averager.sv =====
`timescale 1ns / 1ps
// Inject: each anchor's entry is read in S_RD and rewritten in S_USE (read-modify-write).
// Read tag: S_RD, S_USE, then S_DIV if needed; shared divider, one quotient bit a cycle.
// Read all: S_SCAN steps over the tags; each active tag is read as above; output may stall.
// Clear needs no table pass; config is always ready. One request is in work at a time.
// Reset clears the active flags, the sequencer and the output at once; min_anchors returns to 3.
// The table has no clearing pass: an entry of an inactive tag reads as zero.

module per_tag_distance_averager import ptda_pkg::*; #(
    parameter int TAG_COUNT   = TAG_COUNT_DEF,
    parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptda_in_if.sink    i_req,
    ptda_cfg_if.sink   i_cfg,
    ptda_out_if.source o_res
);

    localparam int     CNT_W   = $clog2(COUNT_LIMIT + 1);
    localparam longint SUM_MAX = longint'(COUNT_LIMIT) * longint'((1 << DIST_W) - 1);
    localparam int     SUM_W   = $clog2(SUM_MAX + 1);
    localparam int     ENTRY_W = SUM_W + CNT_W;
    localparam int     TIDX_W  = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int     DEPTH   = TAG_COUNT * ANCHORS;
    localparam int     ADDR_W  = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_RD      = 8'b0000_0100,
        S_USE     = 8'b0000_1000,
        S_DIV     = 8'b0001_0000,
        S_TAGDONE = 8'b0010_0000,
        S_EMIT    = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    t_op               r_op;
    logic [TAG_W-1:0]  r_tag;
    logic [DIST_W-1:0] r_dist [ANCHORS];
    logic [TIDX_W-1:0] r_idx;
    logic [ANC_W-1:0]  r_anc;
    logic [TAG_COUNT-1:0] r_active;
    logic [MINA_W-1:0] r_min;
    logic [DIST_W-1:0] r_mean [ANCHORS];
    logic              r_any;
    logic [RES_CNT_W-1:0] r_kcnt;
    logic              r_pend_vld;
    logic [TAG_W-1:0]  r_pend_tag;
    logic [DIST_W-1:0] r_pend_mean [ANCHORS];

    logic              r_out_vld;
    logic [TAG_W-1:0]  r_out_tag;
    logic              r_out_vres;
    logic [DIST_W-1:0] r_out_mean [ANCHORS];
    logic              r_out_last;
    logic [TAG_W-1:0]  n_out_tag;
    logic              n_out_vres;
    logic [DIST_W-1:0] n_out_mean [ANCHORS];
    logic              n_out_last;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;

    logic              req_acc;
    t_op               in_op;
    logic [TIDX_W-1:0] in_idx;
    logic              in_range;
    logic              in_active;
    logic [SUM_W-1:0]  rd_sum;
    logic [CNT_W-1:0]  rd_cnt;
    logic              cur_active;
    logic [SUM_W-1:0]  base_sum;
    logic [CNT_W-1:0]  base_cnt;
    logic              take;
    logic [SUM_W-1:0]  wr_sum;
    logic [CNT_W-1:0]  wr_cnt;
    logic              any_dist;
    logic [MINA_W-1:0] nz;
    logic              qualify;
    logic              last_tag;
    logic              last_anc;
    logic              out_free;
    logic              stall;
    logic              out_load;
    logic              div_start;
    logic              div_done;
    logic [DIST_W-1:0] div_quot;

    assign req_acc   = i_req.valid && i_req.ready;
    assign in_op     = t_op'(i_req.opcode);
    assign in_idx    = TIDX_W'(i_req.tag);
    assign in_range  = 32'(i_req.tag) < TAG_COUNT;
    assign in_active = in_range && r_active[in_idx];

    assign mem_addr = ADDR_W'({r_idx, r_anc});
    assign rd_sum   = r_rdata[ENTRY_W-1:CNT_W];
    assign rd_cnt   = r_rdata[CNT_W-1:0];

    // An inactive tag's entry may hold stale data: treat it as empty.
    assign cur_active = r_active[r_idx];
    assign base_sum   = cur_active ? rd_sum : '0;
    assign base_cnt   = cur_active ? rd_cnt : '0;
    assign take       = (r_dist[r_anc] != '0) && (base_cnt < CNT_W'(COUNT_LIMIT));
    assign wr_sum     = take ? base_sum + SUM_W'(r_dist[r_anc]) : base_sum;
    assign wr_cnt     = take ? base_cnt + CNT_W'(1) : base_cnt;
    assign mem_we     = (r_state == S_USE) && (r_op == OP_INJECT);

    always_comb begin
        any_dist = 1'b0;
        nz       = '0;
        for (int a = 0; a < ANCHORS; a++) begin
            any_dist = any_dist | (r_dist[a] != '0);
            nz       = nz + MINA_W'(r_mean[a] != '0);
        end
    end

    assign qualify  = (nz >= r_min) && (r_kcnt < RES_CNT_W'(MAX_RESULTS));
    assign last_tag = r_idx == TIDX_W'(TAG_COUNT - 1);
    assign last_anc = r_anc == ANC_W'(ANCHORS - 1);
    assign out_free = !r_out_vld || o_res.ready;
    assign stall    = qualify && r_pend_vld && !out_free;

    assign div_start = (r_state == S_USE) && (r_op != OP_INJECT) && (rd_cnt != '0);

    ptda_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rd_sum),
        .i_divisor  (rd_cnt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    unique case (in_op)
                        OP_INJECT:   n_state = in_range ? S_RD : S_IDLE;
                        OP_CLEAR:    n_state = S_IDLE;
                        OP_READ:     n_state = in_active ? S_RD : S_EMIT;
                        OP_READ_ALL: n_state = S_SCAN;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (cur_active) begin
                    n_state = S_RD;
                end else if (last_tag) begin
                    n_state = S_FINISH;
                end
            end
            S_RD: n_state = S_USE;
            S_USE: begin
                if (r_op == OP_INJECT) begin
                    n_state = last_anc ? S_IDLE : S_RD;
                end else if (rd_cnt != '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = last_anc ? S_TAGDONE : S_RD;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = last_anc ? S_TAGDONE : S_RD;
                end
            end
            S_TAGDONE: begin
                if (r_op == OP_READ) begin
                    n_state = S_EMIT;
                end else if (!stall) begin
                    n_state = last_tag ? S_FINISH : S_SCAN;
                end
            end
            S_EMIT: n_state = out_free ? S_IDLE : S_EMIT;
            S_FINISH: n_state = out_free ? S_IDLE : S_FINISH;
            default: n_state = S_IDLE;
        endcase
    end

    // Output register loads from the single-read result, the held read-all result, or the
    // empty read-all result.
    always_comb begin
        out_load   = 1'b0;
        n_out_tag  = r_pend_tag;
        n_out_vres = 1'b1;
        n_out_last = 1'b0;
        for (int a = 0; a < ANCHORS; a++) begin
            n_out_mean[a] = r_pend_mean[a];
        end
        unique case (r_state)
            S_EMIT: begin
                out_load   = out_free;
                n_out_tag  = r_tag;
                n_out_vres = r_any;
                n_out_last = 1'b1;
                for (int a = 0; a < ANCHORS; a++) begin
                    n_out_mean[a] = r_mean[a];
                end
            end
            S_FINISH: begin
                out_load   = out_free;
                n_out_last = 1'b1;
                if (!r_pend_vld) begin
                    n_out_tag  = '0;
                    n_out_vres = 1'b0;
                    for (int a = 0; a < ANCHORS; a++) begin
                        n_out_mean[a] = '0;
                    end
                end
            end
            S_TAGDONE: begin
                out_load = (r_op == OP_READ_ALL) && qualify && r_pend_vld && out_free;
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= {wr_sum, wr_cnt};
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_min      <= MINA_RESET;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_kcnt     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_min <= i_cfg.min_anchors;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_kcnt     <= '0;
                        r_pend_vld <= 1'b0;
                        if (in_op == OP_CLEAR && in_range) begin
                            r_active[in_idx] <= 1'b0;
                        end
                    end
                end
                S_USE: begin
                    if (mem_we && last_anc && any_dist) begin
                        r_active[r_idx] <= 1'b1;
                    end
                end
                S_TAGDONE: begin
                    r_active[r_idx] <= 1'b0;
                    if (r_op == OP_READ_ALL && qualify && !stall) begin
                        r_pend_vld <= 1'b1;
                        r_kcnt     <= r_kcnt + RES_CNT_W'(1);
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_pend_vld <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_tag  <= n_out_tag;
            r_out_vres <= n_out_vres;
            r_out_last <= n_out_last;
            for (int a = 0; a < ANCHORS; a++) begin
                r_out_mean[a] <= n_out_mean[a];
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    r_op     <= in_op;
                    r_tag    <= i_req.tag;
                    r_idx    <= (in_op == OP_READ_ALL) ? '0 : in_idx;
                    r_anc    <= '0;
                    r_any    <= 1'b0;
                    r_dist[0] <= i_req.dist0;
                    r_dist[1] <= i_req.dist1;
                    r_dist[2] <= i_req.dist2;
                    r_dist[3] <= i_req.dist3;
                    for (int a = 0; a < ANCHORS; a++) begin
                        r_mean[a] <= '0;
                    end
                end
            end
            S_SCAN: begin
                if (!cur_active && !last_tag) begin
                    r_idx <= r_idx + TIDX_W'(1);
                end
            end
            S_USE: begin
                if (r_op == OP_INJECT) begin
                    r_anc <= r_anc + ANC_W'(1);
                end else if (rd_cnt != '0) begin
                    r_any <= 1'b1;
                end else begin
                    r_mean[r_anc] <= '0;
                    r_anc         <= r_anc + ANC_W'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_mean[r_anc] <= div_quot;
                    r_anc         <= r_anc + ANC_W'(1);
                end
            end
            S_TAGDONE: begin
                if (r_op == OP_READ_ALL && !stall) begin
                    if (qualify) begin
                        r_pend_tag <= TAG_W'(r_idx);
                        for (int a = 0; a < ANCHORS; a++) begin
                            r_pend_mean[a] <= r_mean[a];
                        end
                    end
                    if (!last_tag) begin
                        r_idx <= r_idx + TIDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready     = r_state == S_IDLE;
    assign i_cfg.ready     = 1'b1;
    assign o_res.valid     = r_out_vld;
    assign o_res.tag_out   = r_out_tag;
    assign o_res.valid_res = r_out_vres;
    assign o_res.mean0     = r_out_mean[0];
    assign o_res.mean1     = r_out_mean[1];
    assign o_res.mean2     = r_out_mean[2];
    assign o_res.mean3     = r_out_mean[3];
    assign o_res.last      = r_out_last;

endmodule

// ===== src/ptda_checker.sv =====
`timescale 1ns / 1ps
`include "per_tag_distance_averager_macros.svh"

module ptda_checker import ptda_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic [OP_W-1:0]   i_req_opcode,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [TAG_W-1:0]  i_res_tag,
    input logic              i_res_valid_res,
    input logic [DIST_W-1:0] i_res_mean0,
    input logic [DIST_W-1:0] i_res_mean1,
    input logic [DIST_W-1:0] i_res_mean2,
    input logic [DIST_W-1:0] i_res_mean3,
    input logic              i_res_last
);

    logic [TAG_W+4*DIST_W+1:0] res_payload;
    logic                      read_req;
    logic                      means_zero;

    assign res_payload = {i_res_tag, i_res_valid_res, i_res_mean0, i_res_mean1,
                          i_res_mean2, i_res_mean3, i_res_last};
    assign read_req    = i_req_valid && i_req_ready &&
                         (i_req_opcode == OP_READ || i_req_opcode == OP_READ_ALL);
    assign means_zero  = (i_res_mean0 == '0) && (i_res_mean1 == '0) &&
                         (i_res_mean2 == '0) && (i_res_mean3 == '0);

    // A read always has work after it: the block drops ready.
    `PTDA_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, read_req, !i_req_ready)
    // An unusable result carries no averages and ends its run.
    `PTDA_ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, i_res_valid && !i_res_valid_res, means_zero)
    `PTDA_ASSERT_IMPL(a_invalid_last, i_clk, i_rst_n, i_res_valid && !i_res_valid_res, i_res_last)
    `PTDA_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(res_payload))

endmodule

bind per_tag_distance_averager ptda_checker u_ptda_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_opcode    (i_req.opcode),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_tag       (o_res.tag_out),
    .i_res_valid_res (o_res.valid_res),
    .i_res_mean0     (o_res.mean0),
    .i_res_mean1     (o_res.mean1),
    .i_res_mean2     (o_res.mean2),
    .i_res_mean3     (o_res.mean3),
    .i_res_last      (o_res.last)
);
